// ----- src/wsd_pkg.sv -----
// ============================================================================
// WebSocket deframer package
// Phase codes, header validation codes and the header check used by the
// deframer; its stream interfaces import the package for its types.
// ============================================================================
package wsd_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [3:0]  t_opcode;
    typedef logic [2:0]  t_err;
    typedef logic [2:0]  t_phase;
    typedef logic [63:0] t_len;

    // Parser phases.
    localparam t_phase PH_BYTE0   = 3'd0;
    localparam t_phase PH_BYTE1   = 3'd1;
    localparam t_phase PH_EXTLEN  = 3'd2;
    localparam t_phase PH_KEY     = 3'd3;
    localparam t_phase PH_PAYLOAD = 3'd4;

    // Header validation codes, in the order they are checked.
    localparam t_err ERR_OK            = 3'd0;
    localparam t_err ERR_RSV_BITS      = 3'd1;
    localparam t_err ERR_BAD_OPCODE    = 3'd2;
    localparam t_err ERR_CTRL_FRAG     = 3'd3;
    localparam t_err ERR_CTRL_TOO_LONG = 3'd4;

    // Length codes in header byte 1.
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // Extra header byte counts.
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    localparam t_opcode OPCODE_MAX       = 4'hA;
    localparam t_opcode OPCODE_CTRL_BASE = 4'h8;
    localparam logic [6:0] CTRL_MAX_LEN  = 7'd125;

    // Validation of a completed header. The first failing check wins.
    function automatic t_err wsd_header_error(input t_byte hdr0, input t_len len);
        t_err    err;
        t_opcode op;
        logic    long_len;
        op       = hdr0[3:0];
        long_len = (len[63:7] != 57'd0) || (len[6:0] > CTRL_MAX_LEN);
        priority if (hdr0[6:4] != 3'd0) begin
            err = ERR_RSV_BITS;
        end else if (op > OPCODE_MAX) begin
            err = ERR_BAD_OPCODE;
        end else if ((op >= OPCODE_CTRL_BASE) && !hdr0[7]) begin
            err = ERR_CTRL_FRAG;
        end else if ((op >= OPCODE_CTRL_BASE) && long_len) begin
            err = ERR_CTRL_TOO_LONG;
        end else begin
            err = ERR_OK;
        end
        return err;
    endfunction

endpackage

// ----- src/wsd_in_if.sv -----
// ============================================================================
// WebSocket deframer input stream
// Valid/ready channel that carries one stream byte per transfer.
// ============================================================================
interface wsd_in_if
    import wsd_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

// ----- src/wsd_out_if.sv -----
// ============================================================================
// WebSocket deframer result stream
// Valid/ready channel that carries one header summary or payload byte per
// transfer.
// ============================================================================
interface wsd_out_if
    import wsd_pkg::*;
;
    logic    valid;
    logic    ready;
    logic    kind;
    t_byte   data_byte;
    logic    last_in_frame;
    logic    fin;
    t_opcode opcode;
    logic    masked;
    t_len    payload_length;
    t_err    error_code;

    modport source (
        output valid, output kind, output data_byte, output last_in_frame,
        output fin, output opcode, output masked, output payload_length,
        output error_code, input ready
    );
    modport sink (
        input valid, input kind, input data_byte, input last_in_frame,
        input fin, input opcode, input masked, input payload_length,
        input error_code, output ready
    );
endinterface

// ----- src/websocket_frame_deframer_unit.sv -----
// ============================================================================
// WebSocket frame deframer
// Parses a framed byte stream, emits one header summary per frame and then
// the unmasked payload bytes, the last one marked.
// ============================================================================
//
//  Channel | Direction | Payload                                   | Handshake
//  --------+-----------+-------------------------------------------+----------
//  i_in    | in        | stream_byte                               | valid/ready
//  o_out   | out       | kind, data_byte, last_in_frame, fin,      | valid/ready
//          |           | opcode, masked, payload_length, error_code|
//
//  Every stream byte is handled in the cycle of its transfer: the parser
//  state and the result register are updated at that same clock edge, so one
//  byte per cycle is sustained while o_out is ready, and a result is visible
//  in the cycle after the byte that caused it. The result register is the
//  only buffer; the input is ready whenever that register is empty or is
//  being drained in the same cycle. Reset (synchronous, active low) returns
//  the parser to the start of a frame and empties the result register.
//
module websocket_frame_deframer_unit
    import wsd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    wsd_in_if.sink          i_in,
    wsd_out_if.source       o_out
);

    // ------------------------------------------------------------------------
    // Parser state. Only the phase and the extra byte counter need a reset;
    // the remaining fields are always written before they are used.
    // ------------------------------------------------------------------------
    t_phase     r_phase,    n_phase;
    logic [3:0] r_cnt,      n_cnt;
    t_byte      r_hdr0,     n_hdr0;
    logic       r_mask,     n_mask;
    t_len       r_len,      n_len;
    logic [31:0] r_key,     n_key;
    t_len       r_rem,      n_rem;
    logic [1:0] r_kidx,     n_kidx;
    t_err       r_err,      n_err;

    // Result register.
    logic       r_out_valid;
    logic       r_kind;
    t_byte      r_data;
    logic       r_last;
    logic       r_fin;
    t_opcode    r_opcode;
    logic       r_masked;
    t_len       r_plen;
    t_err       r_ecode;

    // Result produced by the byte being transferred, if any.
    logic       w_emit;
    logic       w_kind;
    t_byte      w_data;
    logic       w_last;

    logic       w_ready;
    logic       w_accept;
    logic       w_finish;
    logic       w_len_done;
    t_byte      w_key_byte;
    t_byte      b;

    // The result register frees up when it is empty or being read now.
    assign w_ready  = !r_out_valid || o_out.ready;
    assign w_accept = i_in.valid && w_ready;
    assign b        = i_in.stream_byte;

    // Key byte for the current payload position; the first key byte sits in
    // the top bits of the key.
    always_comb begin
        unique case (r_kidx)
            2'd0:    w_key_byte = r_key[31:24];
            2'd1:    w_key_byte = r_key[23:16];
            2'd2:    w_key_byte = r_key[15:8];
            default: w_key_byte = r_key[7:0];
        endcase
    end

    // ------------------------------------------------------------------------
    // Next state for one accepted byte.
    // ------------------------------------------------------------------------
    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_hdr0     = r_hdr0;
        n_mask     = r_mask;
        n_len      = r_len;
        n_key      = r_key;
        n_rem      = r_rem;
        n_kidx     = r_kidx;
        n_err      = r_err;
        w_emit     = 1'b0;
        w_kind     = 1'b0;
        w_data     = 8'd0;
        w_last     = 1'b0;
        w_finish   = 1'b0;
        w_len_done = 1'b0;

        unique case (r_phase)
            PH_BYTE1: begin
                // An extended length starts from zero and is shifted in.
                n_mask = b[7];
                n_len  = 64'd0;
                n_key  = 32'd0;
                if (b[6:0] == LEN_CODE_EXT16) begin
                    n_cnt   = EXT16_BYTES;
                    n_phase = PH_EXTLEN;
                end else if (b[6:0] == LEN_CODE_EXT64) begin
                    n_cnt   = EXT64_BYTES;
                    n_phase = PH_EXTLEN;
                end else begin
                    n_len      = {57'd0, b[6:0]};
                    w_len_done = 1'b1;
                end
            end
            PH_EXTLEN: begin
                // Extended length arrives most significant byte first.
                n_len = {r_len[55:0], b};
                if (r_cnt <= 4'd1) begin
                    n_cnt      = 4'd0;
                    w_len_done = 1'b1;
                end else begin
                    n_cnt = r_cnt - 4'd1;
                end
            end
            PH_KEY: begin
                n_key = {r_key[23:0], b};
                if (r_cnt <= 4'd1) begin
                    n_cnt    = 4'd0;
                    w_finish = 1'b1;
                end else begin
                    n_cnt = r_cnt - 4'd1;
                end
            end
            PH_PAYLOAD: begin
                w_emit = 1'b1;
                w_kind = 1'b1;
                w_data = b ^ w_key_byte;
                w_last = (r_rem[63:1] == 63'd0);
                n_kidx = r_kidx + 2'd1;
                if (w_last) begin
                    n_rem   = 64'd0;
                    n_phase = PH_BYTE0;
                end else begin
                    n_rem = r_rem - 64'd1;
                end
            end
            default: begin
                // Header byte 0; unused phase codes land here as well.
                n_hdr0  = b;
                n_phase = PH_BYTE1;
            end
        endcase

        // Once the length is known, a masked frame still needs its key.
        if (w_len_done) begin
            if (n_mask) begin
                n_cnt   = KEY_BYTES;
                n_phase = PH_KEY;
            end else begin
                w_finish = 1'b1;
            end
        end

        // Header complete: validate it and report the summary.
        if (w_finish) begin
            n_err   = wsd_header_error(n_hdr0, n_len);
            n_rem   = n_len;
            n_kidx  = 2'd0;
            n_cnt   = 4'd0;
            w_emit  = 1'b1;
            w_kind  = 1'b0;
            w_data  = 8'd0;
            w_last  = (n_len == 64'd0);
            n_phase = w_last ? PH_BYTE0 : PH_PAYLOAD;
        end
    end

    // ------------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_BYTE0;
            r_cnt       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase <= n_phase;
                r_cnt   <= n_cnt;
            end
            if (w_ready) begin
                r_out_valid <= w_accept && w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hdr0 <= n_hdr0;
            r_mask <= n_mask;
            r_len  <= n_len;
            r_key  <= n_key;
            r_rem  <= n_rem;
            r_kidx <= n_kidx;
            r_err  <= n_err;
        end
        // Header fields of a result always describe the frame that produced
        // it, which the next-state values already reflect.
        if (w_accept && w_emit) begin
            r_kind   <= w_kind;
            r_data   <= w_data;
            r_last   <= w_last;
            r_fin    <= n_hdr0[7];
            r_opcode <= n_hdr0[3:0];
            r_masked <= n_mask;
            r_plen   <= n_len;
            r_ecode  <= n_err;
        end
    end

    assign i_in.ready           = w_ready;
    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_kind;
    assign o_out.data_byte      = r_data;
    assign o_out.last_in_frame  = r_last;
    assign o_out.fin            = r_fin;
    assign o_out.opcode         = r_opcode;
    assign o_out.masked         = r_masked;
    assign o_out.payload_length = r_plen;
    assign o_out.error_code     = r_ecode;

endmodule

// ----- tb/tb_top.sv -----
// ============================================================================
// WebSocket frame deframer testbench
// Streams framed bytes into the deframer through a bursty valid/ready
// source, predicts every header summary and unmasked payload byte in a
// behavioral model, and compares each result transfer field by field while
// the result side stalls on a changing pattern.
// ============================================================================
module tb_top;
    import wsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Number of random stream bytes after the directed frames.
    localparam int RANDOM_BYTES = 1250;
    // Hard stop, far above the slowest legal run of this stimulus.
    localparam int CYCLE_LIMIT  = 400000;
    // Quiet cycles after the last result, to catch anything spurious.
    localparam int DRAIN_CYCLES = 16;

    // Result kinds.
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Opcodes used to build frames.
    localparam t_opcode OP_CONT   = 4'h0;
    localparam t_opcode OP_TEXT   = 4'h1;
    localparam t_opcode OP_BINARY = 4'h2;
    localparam t_opcode OP_CLOSE  = 4'h8;
    localparam t_opcode OP_PING   = 4'h9;
    localparam t_opcode OP_PONG   = 4'hA;
    localparam t_opcode OP_BAD    = 4'hB;
    localparam t_opcode OP_TOP    = 4'hF;

    // How the payload length is encoded in the header.
    localparam int LEN_SHORT = 0;
    localparam int LEN_EXT16 = 1;
    localparam int LEN_EXT64 = 2;

    typedef struct packed {
        logic    kind;
        t_byte   data_byte;
        logic    last_in_frame;
        logic    fin;
        t_opcode opcode;
        logic    masked;
        t_len    payload_length;
        t_err    error_code;
    } t_frame_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    wsd_in_if  in_ch ();
    wsd_out_if out_ch ();

    // The channel inputs are driven from these registers so that they are
    // known from time zero and have a single driver each.
    logic  send_valid = 1'b0;
    t_byte send_byte  = '0;
    logic  take_ready = 1'b0;

    assign in_ch.valid       = send_valid;
    assign in_ch.stream_byte = send_byte;
    assign out_ch.ready      = take_ready;

    websocket_frame_deframer_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Behavioral deframer. It keeps its own copy of the parser state and is
    // stepped once for every stream byte that the block accepts.
    // ------------------------------------------------------------------------
    t_phase        parse_phase = PH_BYTE0;
    logic [3:0]    hdr_bytes_left = '0;
    t_byte         hdr_first = '0;
    logic          mask_on = 1'b0;
    logic [6:0]    len_code = '0;
    t_len          frame_len = '0;
    logic [31:0]   key_word = '0;
    t_len          body_left = '0;
    logic [1:0]    key_pos = '0;

    t_frame_result expected_results[$];
    t_byte         pending_bytes[$];

    int error_count     = 0;
    int bytes_sent      = 0;
    int headers_checked = 0;
    int headers_flagged = 0;
    int payload_checked = 0;
    int cycle_count     = 0;

    // Header validation, first failing check wins.
    function automatic t_err header_verdict(input t_byte h0, input t_len len);
        t_err verdict;
        verdict = ERR_OK;
        if (h0[6:4] != 3'b000) begin
            verdict = ERR_RSV_BITS;
        end else if (h0[3:0] > OPCODE_MAX) begin
            verdict = ERR_BAD_OPCODE;
        end else if (h0[3:0] >= OPCODE_CTRL_BASE) begin
            if (!h0[7]) begin
                verdict = ERR_CTRL_FRAG;
            end else if (len > 64'd125) begin
                verdict = ERR_CTRL_TOO_LONG;
            end
        end
        return verdict;
    endfunction

    // Fields that every result of the current frame repeats.
    function automatic t_frame_result frame_fields();
        t_frame_result r;
        r                = '0;
        r.fin            = hdr_first[7];
        r.opcode         = hdr_first[3:0];
        r.masked         = mask_on;
        r.payload_length = frame_len;
        r.error_code     = header_verdict(hdr_first, frame_len);
        return r;
    endfunction

    task automatic deframe_byte(input t_byte b);
        t_frame_result r;
        logic          len_complete;
        logic          hdr_complete;
        t_byte         key_byte;
        len_complete = 1'b0;
        hdr_complete = 1'b0;
        case (parse_phase)
            PH_BYTE1: begin
                mask_on   = b[7];
                len_code  = b[6:0];
                frame_len = '0;
                key_word  = '0;
                if (len_code == LEN_CODE_EXT16) begin
                    hdr_bytes_left = EXT16_BYTES;
                    parse_phase    = PH_EXTLEN;
                end else if (len_code == LEN_CODE_EXT64) begin
                    hdr_bytes_left = EXT64_BYTES;
                    parse_phase    = PH_EXTLEN;
                end else begin
                    frame_len    = {57'd0, len_code};
                    len_complete = 1'b1;
                end
            end
            PH_EXTLEN: begin
                // Extended length arrives most significant byte first.
                frame_len = {frame_len[55:0], b};
                if (hdr_bytes_left <= 4'd1) begin
                    hdr_bytes_left = '0;
                    len_complete   = 1'b1;
                end else begin
                    hdr_bytes_left = hdr_bytes_left - 4'd1;
                end
            end
            PH_KEY: begin
                key_word = {key_word[23:0], b};
                if (hdr_bytes_left <= 4'd1) begin
                    hdr_bytes_left = '0;
                    hdr_complete   = 1'b1;
                end else begin
                    hdr_bytes_left = hdr_bytes_left - 4'd1;
                end
            end
            PH_PAYLOAD: begin
                // Key bytes are applied from the top byte of the key down.
                key_byte        = key_word[8 * (3 - int'(key_pos)) +: 8];
                r               = frame_fields();
                r.kind          = KIND_PAYLOAD;
                r.data_byte     = b ^ key_byte;
                r.last_in_frame = (body_left <= 64'd1);
                expected_results.push_back(r);
                key_pos = key_pos + 2'd1;
                if (body_left <= 64'd1) begin
                    body_left   = '0;
                    parse_phase = PH_BYTE0;
                end else begin
                    body_left = body_left - 64'd1;
                end
            end
            default: begin
                hdr_first   = b;
                parse_phase = PH_BYTE1;
            end
        endcase

        if (len_complete) begin
            if (mask_on) begin
                hdr_bytes_left = KEY_BYTES;
                parse_phase    = PH_KEY;
            end else begin
                hdr_complete = 1'b1;
            end
        end

        if (hdr_complete) begin
            // An empty frame ends on its header summary.
            r               = frame_fields();
            r.kind          = KIND_HEADER;
            r.last_in_frame = (frame_len == 64'd0);
            expected_results.push_back(r);
            body_left      = frame_len;
            key_pos        = '0;
            hdr_bytes_left = '0;
            parse_phase    = (frame_len == 64'd0) ? PH_BYTE0 : PH_PAYLOAD;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stream building. A frame is queued byte by byte: header byte 0, the
    // length byte, any extended length, the key when masked, then the body.
    // body_count may be shorter than the length for a frame left open at the
    // end of the run.
    // ------------------------------------------------------------------------
    task automatic add_frame(input t_byte h0, input logic masked_frame, input int form,
                             input t_len len, input int body_count);
        logic [31:0] key;
        key = $urandom;
        pending_bytes.push_back(h0);
        case (form)
            LEN_EXT16: begin
                pending_bytes.push_back({masked_frame, LEN_CODE_EXT16});
                pending_bytes.push_back(len[15:8]);
                pending_bytes.push_back(len[7:0]);
            end
            LEN_EXT64: begin
                pending_bytes.push_back({masked_frame, LEN_CODE_EXT64});
                for (int i = 7; i >= 0; i--) begin
                    pending_bytes.push_back(len[8 * i +: 8]);
                end
            end
            default: begin
                pending_bytes.push_back({masked_frame, len[6:0]});
            end
        endcase
        if (masked_frame) begin
            for (int i = 3; i >= 0; i--) begin
                pending_bytes.push_back(key[8 * i +: 8]);
            end
        end
        repeat (body_count) begin
            pending_bytes.push_back(t_byte'($urandom));
        end
    endtask

    initial begin
        int      directed_count;
        int      len_pick;
        int      form;
        int      body;
        logic    fin_bit;
        logic    masked_frame;
        t_opcode op;
        t_byte   h0;

        // Directed frames: an empty final text frame, reserved bits with the
        // top opcode on a masked one-byte frame, an undefined opcode, a
        // fragmented ping, a masked frame with a 16-bit length and an
        // unmasked fragment whose bytes must pass through unchanged.
        add_frame({1'b1, 3'b000, OP_TEXT},   1'b0, LEN_SHORT, 64'd0, 0);
        add_frame({1'b0, 3'b111, OP_TOP},    1'b1, LEN_SHORT, 64'd1, 1);
        add_frame({1'b0, 3'b000, OP_BAD},    1'b0, LEN_SHORT, 64'd0, 0);
        add_frame({1'b0, 3'b000, OP_PING},   1'b0, LEN_SHORT, 64'd0, 0);
        add_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, LEN_EXT16, 64'd3, 3);
        add_frame({1'b0, 3'b000, OP_BINARY}, 1'b0, LEN_SHORT, 64'd2, 2);
        directed_count = pending_bytes.size();

        // Random frames. Most are well formed with random content; about one
        // in eight gets a fully random first byte, which exercises reserved
        // bits and undefined opcodes. Lengths stay small so that frames keep
        // closing, with a share of long short-form codes and control frames
        // just above the control limit.
        while (pending_bytes.size() < directed_count + RANDOM_BYTES) begin
            if ($urandom_range(0, 7) == 0) begin
                h0 = t_byte'($urandom);
            end else begin
                fin_bit = ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 5))
                    0:       op = OP_CONT;
                    1:       op = OP_TEXT;
                    2:       op = OP_BINARY;
                    3:       op = OP_CLOSE;
                    4:       op = OP_PING;
                    default: op = OP_PONG;
                endcase
                h0 = {fin_bit, 3'b000, op};
            end
            masked_frame = 1'($urandom_range(0, 1));
            len_pick     = $urandom_range(0, 15);
            if (len_pick <= 9) begin
                form = LEN_SHORT;
                body = $urandom_range(0, 12);
            end else if (len_pick == 10) begin
                form = LEN_SHORT;
                body = $urandom_range(64, 125);
            end else if (len_pick <= 12) begin
                form = LEN_EXT16;
                body = $urandom_range(0, 140);
            end else if (len_pick == 13) begin
                form = LEN_EXT64;
                body = $urandom_range(0, 24);
            end else if (len_pick == 14) begin
                form = LEN_SHORT;
                body = 0;
            end else begin
                form = LEN_EXT16;
                body = $urandom_range(0, 8);
            end
            add_frame(h0, masked_frame, form, t_len'(body), body);
        end

        // Final frame: a masked close frame whose 64-bit length has the top
        // bit set. It is flagged as too long for a control frame and stays
        // open after its first two payload bytes, since nothing follows it.
        add_frame({1'b1, 3'b000, OP_CLOSE}, 1'b1, LEN_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 2);

        // Reset is held from time zero and released at a clock edge.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every byte to be taken, then for every result, then let the
        // quiet drain period pass so that stray results are still caught.
        while (pending_bytes.size() != 0 || send_valid) begin
            @(posedge i_clk);
        end
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb_top: %0d stream bytes sent, %0d frame headers checked (%0d flagged)",
                 bytes_sent, headers_checked, headers_flagged);
        $display("tb_top: %0d payload bytes checked, %0d mismatches",
                 payload_checked, error_count);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Source driver. Bytes leave the queue in bursts of random length; most
    // bursts are followed by a random gap, some run back to back, and now
    // and then a long burst has no gaps at all. The model is stepped at the
    // edge where a transfer completes.
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        logic  take;
        logic  nxt_valid;
        t_byte nxt_byte;
        if (!i_rst_n) begin
            send_valid <= 1'b0;
            send_byte  <= '0;
        end else begin
            take      = send_valid && in_ch.ready;
            nxt_valid = send_valid;
            nxt_byte  = send_byte;
            if (take) begin
                deframe_byte(send_byte);
                bytes_sent++;
            end
            // A byte on offer is held until it is taken.
            if (!send_valid || take) begin
                if (gap_left > 0) begin
                    gap_left--;
                    nxt_valid = 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    nxt_valid = 1'b1;
                    nxt_byte  = pending_bytes.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else if ($urandom_range(0, 9) == 0) begin
                        burst_left = $urandom_range(100, 300);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end else begin
                    nxt_valid = 1'b0;
                end
            end
            send_valid <= nxt_valid;
            send_byte  <= nxt_byte;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. Ready follows a 16-bit pattern that rotates every
    // cycle and is replaced after a random stretch: always ready, random,
    // mostly stalled or mostly ready. Each completed transfer is compared
    // with the oldest expected result.
    // ------------------------------------------------------------------------
    logic [15:0] stall_pattern = 16'hFFFF;
    int          pattern_left  = 0;

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_result want;
        if (!i_rst_n) begin
            take_ready <= 1'b0;
        end else begin
            if (out_ch.valid && take_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0b data %0h",
                             $time, out_ch.kind, out_ch.data_byte);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", 64'(want.kind), 64'(out_ch.kind));
                    check_field("data_byte", 64'(want.data_byte), 64'(out_ch.data_byte));
                    check_field("last_in_frame", 64'(want.last_in_frame),
                                64'(out_ch.last_in_frame));
                    check_field("fin", 64'(want.fin), 64'(out_ch.fin));
                    check_field("opcode", 64'(want.opcode), 64'(out_ch.opcode));
                    check_field("masked", 64'(want.masked), 64'(out_ch.masked));
                    check_field("payload_length", want.payload_length,
                                out_ch.payload_length);
                    check_field("error_code", 64'(want.error_code), 64'(out_ch.error_code));
                    if (want.kind == KIND_HEADER) begin
                        headers_checked++;
                        if (want.error_code != ERR_OK) begin
                            headers_flagged++;
                        end
                    end else begin
                        payload_checked++;
                    end
                end
            end
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(16, 200);
                case ($urandom_range(0, 3))
                    0:       stall_pattern = 16'hFFFF;
                    1:       stall_pattern = 16'($urandom);
                    2:       stall_pattern = 16'($urandom) & 16'($urandom);
                    default: stall_pattern = 16'($urandom) | 16'($urandom);
                endcase
            end else begin
                pattern_left--;
                stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
            end
            take_ready <= stall_pattern[0];
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d bytes queued and %0d results outstanding",
                     $time, pending_bytes.size(), expected_results.size());
            $display("tb_top: errors");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
src/wsd_pkg.sv
src/wsd_in_if.sv
src/wsd_out_if.sv
src/websocket_frame_deframer_unit.sv
tb/tb_top.sv
